>>> src/prgcc_pkg.sv
// Package for the proportional-resonant grid current controller.
// Holds shared types, fixed-point constants and the sine polynomial table.
// No dependencies.
package prgcc_pkg;

    localparam int MAX_SUBSTEPS = 16;
    localparam int PHASE_BITS   = 16;

    localparam int ANG_W    = 16;
    localparam int PHASE_KEEP = (PHASE_BITS < ANG_W) ? PHASE_BITS : ANG_W;
    localparam logic [ANG_W-1:0] ANG_MASK = {ANG_W{1'b1}} << (ANG_W - PHASE_KEEP);

    localparam logic signed [63:0] WIDE_LIM = 64'sh4000_0000_0000_0000;
    localparam logic [63:0]        Q30_ONE  = 64'd1073741824;
    localparam logic [63:0]        W2_COEF  = 64'd4340697920;
    localparam logic signed [47:0] RES_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] RES_MIN  = 48'sh8000_0000_0000;

    localparam logic [23:0] PROP_GAIN_RST    = 24'd25600;
    localparam logic [27:0] INTEG_GAIN_RST   = 28'd2048000;
    localparam logic [39:0] SUBSTEP_TIME_RST = 40'd54975581;
    localparam logic [4:0]  OVERSAMPLE_RST   = 5'd1;
    localparam logic [22:0] RATE_LIMIT_RST   = 23'd410;

    typedef enum logic [1:0] {
        SH_0,
        SH_8,
        SH_30,
        SH_40
    } t_shift;

    // One request to the shared multiply-and-scale unit
    typedef struct packed {
        logic signed [63:0] a;
        logic [63:0]        b;
        t_shift             sh;
    } t_mpy_req;

    typedef enum logic [2:0] {
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_SUBSTEP_TIME,
        REG_OVERSAMPLE,
        REG_RATE_LIMIT
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN_Z2,
        ST_SIN_POLY,
        ST_SIN_ZP,
        ST_ROT,
        ST_FF,
        ST_W2,
        ST_DRIVE,
        ST_X1,
        ST_TW,
        ST_X2,
        ST_PROP,
        ST_EMIT
    } t_state;

    // Odd polynomial coefficients of the quarter-wave sine, Q1.30
    function automatic logic [30:0] sin_coef(input logic [2:0] idx);
        logic [30:0] c;
        case (idx)
            3'd0:    c = 31'd1686629713;
            3'd1:    c = 31'd693598668;
            3'd2:    c = 31'd85569306;
            3'd3:    c = 31'd5026995;
            3'd4:    c = 31'd172272;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

endpackage

>>> src/prgcc_mpy.sv
// Shared multiply-and-scale unit: floor(a * b / 2^sh), saturated to 2^62.
// One 32x32 multiplier walks four partial products into a 128-bit accumulator.
// Depends on prgcc_pkg.
module prgcc_mpy (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  prgcc_pkg::t_mpy_req       i_req,
    output logic                      o_done,
    output logic signed [63:0]        o_res
);

    logic [63:0]        r_a;
    logic [63:0]        r_b;
    logic               r_neg;
    prgcc_pkg::t_shift  r_sh;
    logic [127:0]       r_acc;
    logic [63:0]        r_pp;
    logic [1:0]         r_pos;
    logic [2:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic signed [63:0] r_res;

    logic signed [63:0] a_clamp;
    logic [63:0]        a_mag;
    logic [31:0]        a_half;
    logic [31:0]        b_half;
    logic [127:0]       pp_ext;
    logic [127:0]       acc_shift;
    logic               rem;
    logic [63:0]        q;
    logic [63:0]        n_res;

    always_comb begin
        if (i_req.a > prgcc_pkg::WIDE_LIM) begin
            a_clamp = prgcc_pkg::WIDE_LIM;
        end else if (i_req.a < -prgcc_pkg::WIDE_LIM) begin
            a_clamp = -prgcc_pkg::WIDE_LIM;
        end else begin
            a_clamp = i_req.a;
        end
        a_mag = (a_clamp < 0) ? 64'(-a_clamp) : 64'(a_clamp);
    end

    assign a_half = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_half = r_cnt[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (r_pos)
            2'd0:    pp_ext = {64'd0, r_pp};
            2'd1:    pp_ext = {32'd0, r_pp, 32'd0};
            default: pp_ext = {r_pp, 64'd0};
        endcase
    end

    always_comb begin
        case (r_sh)
            prgcc_pkg::SH_0: begin
                acc_shift = r_acc;
                rem       = 1'b0;
            end
            prgcc_pkg::SH_8: begin
                acc_shift = r_acc >> 8;
                rem       = |r_acc[7:0];
            end
            prgcc_pkg::SH_30: begin
                acc_shift = r_acc >> 30;
                rem       = |r_acc[29:0];
            end
            default: begin
                acc_shift = r_acc >> 40;
                rem       = |r_acc[39:0];
            end
        endcase
        q = (acc_shift > 128'(prgcc_pkg::WIDE_LIM)) ? 64'(prgcc_pkg::WIDE_LIM)
                                                    : acc_shift[63:0];
        n_res = r_neg ? (64'd0 - q - 64'(rem)) : q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= a_mag;
            r_b   <= i_req.b;
            r_neg <= (a_clamp < 0);
            r_sh  <= i_req.sh;
            r_acc <= 128'd0;
        end else if (r_busy) begin
            if (r_cnt < 3'd4) begin
                r_pp  <= a_half * b_half;
                r_pos <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + pp_ext;
            end
            if (r_cnt == 3'd5) begin
                r_res <= $signed(n_res);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> src/pr_grid_current_controller.sv
// Top level of the proportional-resonant grid current controller.
// Sequencer, configuration registers and controller state; uses prgcc_pkg and prgcc_mpy.
//
// One item at a time: every product goes through one shared 32x32 multiplier, and
// an item needs 22 + 6*n scaled multiplies (n = substeps). The input is not ready
// until the result is handed to the output register.
// Writing prop_gain or integ_gain clears setpoint and integrators; write only while idle.
module pr_grid_current_controller (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // meas_alpha[23:0], meas_beta[47:24], want_d[71:48], want_q[95:72],
    // phase_angle[111:96], grid_freq[125:112], zero[127:126]
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // volt_alpha[31:0], volt_beta[63:32]
    output logic [63:0]  o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [39:0]  i_cfg_data
);

    prgcc_pkg::t_state   r_state;
    prgcc_pkg::t_state   n_state;

    logic [23:0]         r_prop_gain;
    logic [27:0]         r_integ_gain;
    logic [39:0]         r_substep_time;
    logic [4:0]          r_oversample;
    logic [22:0]         r_rate_limit;

    logic signed [23:0]  r_sp [2];
    logic signed [47:0]  r_x1 [2];
    logic signed [47:0]  r_x2 [2];
    logic signed [23:0]  r_meas [2];
    logic signed [26:0]  r_err [2];

    logic [15:0]         r_ang;
    logic [13:0]         r_f;
    logic [30:0]         r_z;
    logic                r_qneg;
    logic [30:0]         r_z2;
    logic [31:0]         r_p;
    logic signed [31:0]  r_sin;
    logic signed [31:0]  r_cos;
    logic signed [57:0]  r_rot;
    logic [27:0]         r_ff;
    logic [60:0]         r_w2;
    logic signed [47:0]  r_drive;
    logic signed [63:0]  r_t;
    logic signed [31:0]  r_va;
    logic signed [31:0]  r_vb;
    logic                r_k;
    logic [1:0]          r_j;
    logic [4:0]          r_i;
    logic                r_pend;
    logic                r_ovalid;
    logic [63:0]         r_odata;

    logic                in_acc;
    logic                mpy_start;
    logic                mpy_done;
    logic signed [63:0]  mpy_res;
    prgcc_pkg::t_mpy_req mpy_req;
    logic [4:0]          n_sub;
    logic                last_sub;
    logic                emit_go;
    logic signed [23:0]  rot_x;
    logic signed [31:0]  rot_y;
    logic signed [57:0]  rot_sum;
    logic [15:0]         ang_in;
    logic [15:0]         ang_cos;
    logic [31:0]         s_mag;
    logic signed [31:0]  s_val;
    logic signed [31:0]  v_out;

    // Fold a 16-bit turn fraction into the first quadrant, Q1.30
    function automatic logic [30:0] z_of(input logic [15:0] ang);
        logic [30:0] r;
        r = {1'b0, ang[13:0], 16'd0};
        return ang[14] ? (31'(prgcc_pkg::Q30_ONE) - r) : r;
    endfunction

    function automatic logic signed [23:0] limit_step(input logic signed [23:0] want,
                                                      input logic signed [23:0] last,
                                                      input logic [22:0] lim);
        logic signed [24:0] diff;
        logic signed [24:0] slim;
        logic signed [24:0] delta;
        logic signed [24:0] sum;
        diff = 25'(want) - 25'(last);
        slim = $signed({2'b00, lim});
        if (diff > slim) begin
            delta = slim;
        end else if (diff < -slim) begin
            delta = -slim;
        end else begin
            delta = diff;
        end
        sum = 25'(last) + delta;
        return sum[23:0];
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [63:0] x,
                                                   input logic signed [63:0] r);
        logic signed [64:0] s;
        s = 65'(x) + 65'(r);
        if (s > 65'(prgcc_pkg::RES_MAX)) begin
            return prgcc_pkg::RES_MAX;
        end else if (s < 65'(prgcc_pkg::RES_MIN)) begin
            return prgcc_pkg::RES_MIN;
        end
        return s[47:0];
    endfunction

    prgcc_mpy u_mpy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mpy_start),
        .i_req   (mpy_req),
        .o_done  (mpy_done),
        .o_res   (mpy_res)
    );

    assign o_s_axis_tready = (r_state == prgcc_pkg::ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    assign n_sub    = (int'(r_oversample) > prgcc_pkg::MAX_SUBSTEPS)
                      ? 5'(prgcc_pkg::MAX_SUBSTEPS) : r_oversample;
    assign last_sub = ((r_i + 5'd1) == n_sub);
    assign emit_go  = !r_ovalid || i_m_axis_tready;
    assign ang_in   = i_s_axis_tdata[111:96] & prgcc_pkg::ANG_MASK;
    assign ang_cos  = r_ang + 16'h4000;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prgcc_pkg::ST_IDLE:     if (in_acc) n_state = prgcc_pkg::ST_SIN_Z2;
            prgcc_pkg::ST_SIN_Z2:   if (mpy_done) n_state = prgcc_pkg::ST_SIN_POLY;
            prgcc_pkg::ST_SIN_POLY: if (mpy_done && r_j == 2'd0) n_state = prgcc_pkg::ST_SIN_ZP;
            prgcc_pkg::ST_SIN_ZP: begin
                if (mpy_done) n_state = r_k ? prgcc_pkg::ST_ROT : prgcc_pkg::ST_SIN_Z2;
            end
            prgcc_pkg::ST_ROT:      if (mpy_done && r_j == 2'd3) n_state = prgcc_pkg::ST_FF;
            prgcc_pkg::ST_FF:       if (mpy_done) n_state = prgcc_pkg::ST_W2;
            prgcc_pkg::ST_W2:       if (mpy_done) n_state = prgcc_pkg::ST_DRIVE;
            prgcc_pkg::ST_DRIVE: begin
                if (mpy_done) begin
                    n_state = (n_sub == 5'd0) ? prgcc_pkg::ST_PROP : prgcc_pkg::ST_X1;
                end
            end
            prgcc_pkg::ST_X1:       if (mpy_done) n_state = prgcc_pkg::ST_TW;
            prgcc_pkg::ST_TW:       if (mpy_done) n_state = prgcc_pkg::ST_X2;
            prgcc_pkg::ST_X2: begin
                if (mpy_done) n_state = last_sub ? prgcc_pkg::ST_PROP : prgcc_pkg::ST_X1;
            end
            prgcc_pkg::ST_PROP: begin
                if (mpy_done) n_state = r_k ? prgcc_pkg::ST_EMIT : prgcc_pkg::ST_DRIVE;
            end
            prgcc_pkg::ST_EMIT:     if (emit_go) n_state = prgcc_pkg::ST_IDLE;
            default:                n_state = prgcc_pkg::ST_IDLE;
        endcase
    end

    assign rot_x = r_j[0] ? r_sp[1] : r_sp[0];
    assign rot_y = (r_j[0] ^ r_j[1]) ? r_sin : r_cos;

    // Multiplier requests per state
    always_comb begin
        mpy_req.a  = 64'sd0;
        mpy_req.b  = 64'd0;
        mpy_req.sh = prgcc_pkg::SH_0;
        mpy_start  = 1'b0;
        unique case (r_state)
            prgcc_pkg::ST_SIN_Z2: begin
                mpy_req.a  = 64'(r_z);
                mpy_req.b  = 64'(r_z);
                mpy_req.sh = prgcc_pkg::SH_30;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_SIN_POLY: begin
                mpy_req.a  = 64'(r_z2);
                mpy_req.b  = 64'(r_p);
                mpy_req.sh = prgcc_pkg::SH_30;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_SIN_ZP: begin
                mpy_req.a  = 64'(r_z);
                mpy_req.b  = 64'(r_p);
                mpy_req.sh = prgcc_pkg::SH_30;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_ROT: begin
                // keep b unsigned: move the sign of the sine or cosine term onto a
                mpy_req.a  = (rot_y < 0) ? -64'(rot_x) : 64'(rot_x);
                mpy_req.b  = (rot_y < 0) ? 64'(-rot_y) : 64'(rot_y);
                mpy_req.sh = prgcc_pkg::SH_0;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_FF: begin
                mpy_req.a  = 64'(r_f);
                mpy_req.b  = 64'(r_f);
                mpy_req.sh = prgcc_pkg::SH_0;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_W2: begin
                mpy_req.a  = 64'(r_ff);
                mpy_req.b  = prgcc_pkg::W2_COEF;
                mpy_req.sh = prgcc_pkg::SH_0;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_DRIVE: begin
                mpy_req.a  = 64'(r_err[r_k]);
                mpy_req.b  = 64'(r_integ_gain);
                mpy_req.sh = prgcc_pkg::SH_8;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_X1: begin
                mpy_req.a  = 64'(r_drive) - 64'(r_x2[r_k]);
                mpy_req.b  = 64'(r_substep_time);
                mpy_req.sh = prgcc_pkg::SH_40;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_TW: begin
                mpy_req.a  = 64'(r_x1[r_k]);
                mpy_req.b  = 64'(r_w2);
                mpy_req.sh = prgcc_pkg::SH_40;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_X2: begin
                mpy_req.a  = r_t;
                mpy_req.b  = 64'(r_substep_time);
                mpy_req.sh = prgcc_pkg::SH_40;
                mpy_start  = !r_pend;
            end
            prgcc_pkg::ST_PROP: begin
                mpy_req.a  = 64'(r_err[r_k]);
                mpy_req.b  = 64'(r_prop_gain);
                mpy_req.sh = prgcc_pkg::SH_8;
                mpy_start  = !r_pend;
            end
            default: begin
                mpy_start = 1'b0;
            end
        endcase
    end

    // Datapath helpers
    always_comb begin
        s_mag   = (mpy_res > 64'(prgcc_pkg::Q30_ONE)) ? 32'(prgcc_pkg::Q30_ONE)
                                                      : mpy_res[31:0];
        s_val   = r_qneg ? -$signed(s_mag) : $signed(s_mag);
        rot_sum = (r_j == 2'd1) ? (r_rot - mpy_res[57:0]) : (r_rot + mpy_res[57:0]);
        begin
            logic signed [64:0] v;
            v = 65'(mpy_res) + 65'(r_x1[r_k]);
            if (v > 65'sd2147483647) begin
                v_out = 32'sh7FFF_FFFF;
            end else if (v < -65'sd2147483648) begin
                v_out = 32'sh8000_0000;
            end else begin
                v_out = v[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prgcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend         <= 1'b0;
            r_ovalid       <= 1'b0;
            r_k            <= 1'b0;
            r_j            <= 2'd0;
            r_i            <= 5'd0;
            r_prop_gain    <= prgcc_pkg::PROP_GAIN_RST;
            r_integ_gain   <= prgcc_pkg::INTEG_GAIN_RST;
            r_substep_time <= prgcc_pkg::SUBSTEP_TIME_RST;
            r_oversample   <= prgcc_pkg::OVERSAMPLE_RST;
            r_rate_limit   <= prgcc_pkg::RATE_LIMIT_RST;
            r_sp[0]        <= 24'sd0;
            r_sp[1]        <= 24'sd0;
            r_x1[0]        <= 48'sd0;
            r_x1[1]        <= 48'sd0;
            r_x2[0]        <= 48'sd0;
            r_x2[1]        <= 48'sd0;
        end else begin
            if (mpy_start) begin
                r_pend <= 1'b1;
            end else if (mpy_done) begin
                r_pend <= 1'b0;
            end
            if (r_state == prgcc_pkg::ST_EMIT && emit_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                prgcc_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_sp[0]   <= limit_step(i_s_axis_tdata[71:48], r_sp[0], r_rate_limit);
                        r_sp[1]   <= limit_step(i_s_axis_tdata[95:72], r_sp[1], r_rate_limit);
                        r_meas[0] <= i_s_axis_tdata[23:0];
                        r_meas[1] <= i_s_axis_tdata[47:24];
                        r_ang     <= ang_in;
                        r_f       <= i_s_axis_tdata[125:112];
                        r_z       <= z_of(ang_in);
                        r_qneg    <= ang_in[15];
                        r_p       <= 32'(prgcc_pkg::sin_coef(3'd4));
                        r_j       <= 2'd3;
                        r_k       <= 1'b0;
                    end
                end
                prgcc_pkg::ST_SIN_Z2: begin
                    if (mpy_done) r_z2 <= mpy_res[30:0];
                end
                prgcc_pkg::ST_SIN_POLY: begin
                    if (mpy_done) begin
                        r_p <= 32'(prgcc_pkg::sin_coef({1'b0, r_j})) - mpy_res[31:0];
                        r_j <= r_j - 2'd1;
                    end
                end
                prgcc_pkg::ST_SIN_ZP: begin
                    if (mpy_done) begin
                        if (!r_k) begin
                            r_sin  <= s_val;
                            r_k    <= 1'b1;
                            r_z    <= z_of(ang_cos);
                            r_qneg <= ang_cos[15];
                            r_p    <= 32'(prgcc_pkg::sin_coef(3'd4));
                            r_j    <= 2'd3;
                        end else begin
                            r_cos <= s_val;
                            r_k   <= 1'b0;
                            r_j   <= 2'd0;
                            r_rot <= 58'sd536870912;
                        end
                    end
                end
                prgcc_pkg::ST_ROT: begin
                    if (mpy_done) begin
                        r_j <= r_j + 2'd1;
                        if (r_j[0]) begin
                            r_err[r_j[1]] <= 27'(rot_sum >>> 30) - 27'(r_meas[r_j[1]]);
                            r_rot         <= 58'sd536870912;
                        end else begin
                            r_rot <= rot_sum;
                        end
                    end
                end
                prgcc_pkg::ST_FF: begin
                    if (mpy_done) r_ff <= mpy_res[27:0];
                end
                prgcc_pkg::ST_W2: begin
                    if (mpy_done) r_w2 <= mpy_res[60:0];
                end
                prgcc_pkg::ST_DRIVE: begin
                    if (mpy_done) begin
                        r_drive <= mpy_res[47:0];
                        r_i     <= 5'd0;
                    end
                end
                prgcc_pkg::ST_X1: begin
                    if (mpy_done) r_x1[r_k] <= clamp48(64'(r_x1[r_k]), mpy_res);
                end
                prgcc_pkg::ST_TW: begin
                    if (mpy_done) r_t <= mpy_res;
                end
                prgcc_pkg::ST_X2: begin
                    if (mpy_done) begin
                        r_x2[r_k] <= clamp48(64'(r_x2[r_k]), mpy_res);
                        r_i       <= r_i + 5'd1;
                    end
                end
                prgcc_pkg::ST_PROP: begin
                    if (mpy_done) begin
                        r_k <= ~r_k;
                        if (!r_k) begin
                            r_va <= v_out;
                        end else begin
                            r_vb <= v_out;
                        end
                    end
                end
                prgcc_pkg::ST_EMIT: begin
                    // load the output only once the previous transfer has left
                    if (emit_go) r_odata <= {r_vb, r_va};
                end
                default: begin
                    r_k <= 1'b0;
                end
            endcase

            // the user must write registers only while idle; the block does not enforce it
            if (i_cfg_we) begin
                unique case (prgcc_pkg::t_reg_idx'(i_cfg_idx))
                    prgcc_pkg::REG_PROP_GAIN,
                    prgcc_pkg::REG_INTEG_GAIN: begin
                        if (prgcc_pkg::t_reg_idx'(i_cfg_idx) == prgcc_pkg::REG_PROP_GAIN) begin
                            r_prop_gain <= i_cfg_data[23:0];
                        end else begin
                            r_integ_gain <= i_cfg_data[27:0];
                        end
                        r_sp[0] <= 24'sd0;
                        r_sp[1] <= 24'sd0;
                        r_x1[0] <= 48'sd0;
                        r_x1[1] <= 48'sd0;
                        r_x2[0] <= 48'sd0;
                        r_x2[1] <= 48'sd0;
                    end
                    prgcc_pkg::REG_SUBSTEP_TIME: r_substep_time <= i_cfg_data;
                    prgcc_pkg::REG_OVERSAMPLE:   r_oversample   <= i_cfg_data[4:0];
                    prgcc_pkg::REG_RATE_LIMIT:   r_rate_limit   <= i_cfg_data[22:0];
                    default: begin
                        r_rate_limit <= r_rate_limit;
                    end
                endcase
            end
        end
    end

endmodule

>>> test/tb_pr_grid_current_controller.sv
// Testbench for pr_grid_current_controller: drives d/q setpoints and measured currents,
// predicts the saturated alpha/beta voltage command and checks every output transfer.
// Depends on prgcc_pkg and the controller RTL.
module tb_pr_grid_current_controller;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // meas_alpha, meas_beta, want_d, want_q, phase_angle, grid_freq, zero pad
    logic [127:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // volt_alpha, volt_beta
    logic [63:0]  o_m_axis_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [39:0]  i_cfg_data;

    pr_grid_current_controller u_dut (.*);

    typedef struct {
        logic signed [23:0] meas_a, meas_b, want_d, want_q;
        logic [15:0] phase;
        logic [13:0] freq;
    } t_item;

    typedef struct {
        logic [31:0] va, vb;
        bit          fixed;
    } t_volt;

    // controller copy
    logic [23:0] kp;
    logic [27:0] ki;
    logic [39:0] dt;
    logic [4:0]  nsub;
    logic [22:0] rlim;
    longint sp_dq[2];
    longint x1[2];
    longint x2[2];

    t_volt  volt_q[$];
    int     n_err;
    int     n_sent;
    int     idle_pct;
    int     stall_pct;
    bit     hold_out;
    int     quiet;

    localparam longint WLIM = 64'sh4000_0000_0000_0000;
    localparam longint RMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint RMIN = -RMAX - 1;

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint fshift(longint x, int n);
        return x >>> n;
    endfunction

    // floor(a*b / 2^sh) with a and the result held to magnitude 2^62
    function automatic longint scale_mul(longint a, logic [63:0] b, int sh);
        logic [127:0] p;
        logic [127:0] q;
        bit           neg;
        bit           rem;
        logic [63:0]  m;
        a = clip(a, -WLIM, WLIM);
        neg = a < 0;
        m = neg ? -a : a;
        p = {64'd0, m} * {64'd0, b};
        q = p >> sh;
        rem = sh != 0 && (p & ((128'd1 << sh) - 1)) != 0;
        if (q > WLIM) q = WLIM;
        return neg ? -longint'(q[63:0]) - (rem ? 1 : 0) : longint'(q[63:0]);
    endfunction

    function automatic longint sin_q30(logic [31:0] ph);
        logic [1:0]  quad;
        logic [63:0] r, z, z2, p;
        longint      s;
        longint      coef[5];
        coef = '{1686629713, 693598668, 85569306, 5026995, 172272};
        quad = ph[31:30];
        r = {34'd0, ph[29:0]};
        z = quad[0] ? 64'd1073741824 - r : r;
        z2 = (z * z) >> 30;
        p = coef[4];
        for (int i = 3; i >= 0; i--) p = coef[i] - longint'((z2 * p) >> 30);
        s = longint'((z * p) >> 30);
        if (s > 1073741824) s = 1073741824;
        return quad[1] ? -s : s;
    endfunction

    function automatic void clear_ctrl();
        for (int k = 0; k < 2; k++) begin
            sp_dq[k] = 0; x1[k] = 0; x2[k] = 0;
        end
    endfunction

    function automatic void apply_reg(prgcc_pkg::t_reg_idx idx, logic [39:0] v);
        case (idx)
            prgcc_pkg::REG_PROP_GAIN:    begin kp = v[23:0]; clear_ctrl(); end
            prgcc_pkg::REG_INTEG_GAIN:   begin ki = v[27:0]; clear_ctrl(); end
            prgcc_pkg::REG_SUBSTEP_TIME: dt = v;
            prgcc_pkg::REG_OVERSAMPLE:   nsub = v[4:0];
            prgcc_pkg::REG_RATE_LIMIT:   rlim = v[22:0];
            default: ;
        endcase
    endfunction

    function automatic t_volt voltage_cmd(t_item it);
        t_volt       o;
        longint      meas[2], want[2], err[2], lim, s, c, d, q, drive, v, t;
        logic [31:0] ph;
        logic [63:0] w2;
        int          n;
        meas[0] = it.meas_a; meas[1] = it.meas_b;
        want[0] = it.want_d; want[1] = it.want_q;
        lim = rlim;
        for (int k = 0; k < 2; k++) sp_dq[k] += clip(want[k] - sp_dq[k], -lim, lim);
        ph = {it.phase & prgcc_pkg::ANG_MASK, 16'd0};
        s = sin_q30(ph);
        c = sin_q30(ph + 32'h4000_0000);
        d = sp_dq[0]; q = sp_dq[1];
        err[0] = fshift(d * c - q * s + 536870912, 30) - meas[0];
        err[1] = fshift(d * s + q * c + 536870912, 30) - meas[1];
        w2 = 64'(it.freq) * 64'(it.freq) * prgcc_pkg::W2_COEF;
        n = nsub > prgcc_pkg::MAX_SUBSTEPS ? prgcc_pkg::MAX_SUBSTEPS : nsub;
        for (int k = 0; k < 2; k++) begin
            drive = fshift(err[k] * longint'(ki), 8);
            for (int i = 0; i < n; i++) begin
                x1[k] = clip(x1[k] + scale_mul(drive - x2[k], dt, 40), RMIN, RMAX);
                t = scale_mul(x1[k], w2, 40);
                x2[k] = clip(x2[k] + scale_mul(t, dt, 40), RMIN, RMAX);
            end
            v = clip(fshift(err[k] * longint'(kp), 8) + x1[k],
                     -64'sd2147483648, 64'sd2147483647);
            if (k == 0) o.va = v[31:0]; else o.vb = v[31:0];
        end
        o.fixed = 0;
        return o;
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && (i_s_axis_tvalid && o_s_axis_tready || o_m_axis_tvalid && i_m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 200000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stall, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_out) i_m_axis_tready <= 0;
        else i_m_axis_tready <= $urandom_range(99) >= stall_pct;
    end

    always @(posedge i_clk) begin
        t_volt e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (volt_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected output %h", o_m_axis_tdata);
            end else begin
                e = volt_q.pop_front();
                if (o_m_axis_tdata[31:0] !== e.va || o_m_axis_tdata[63:32] !== e.vb) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp a=%h b=%h got a=%h b=%h",
                                 e.va, e.vb, o_m_axis_tdata[31:0], o_m_axis_tdata[63:32]);
                end
            end
        end
    end

    // tvalid stays high after a transfer until the next item or an idle cycle drops it
    task automatic send_item(t_item it, bit has_exp, logic [31:0] ea, logic [31:0] eb);
        t_volt e;
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_axis_tdata <= {2'b0, it.freq, it.phase, it.want_q, it.want_d, it.meas_b, it.meas_a};
        i_s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        e = voltage_cmd(it);
        if (has_exp) begin
            e.va = ea; e.vb = eb;
        end
        volt_q.push_back(e);
        n_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_s_axis_tvalid <= 0;
        while (volt_q.size() != 0 && guard < 400000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(prgcc_pkg::t_reg_idx idx, logic [39:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        apply_reg(idx, v);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_item rand_item(bit well);
        t_item it;
        it.meas_a = 24'($urandom); it.meas_b = 24'($urandom);
        it.want_d = 24'($urandom); it.want_q = 24'($urandom);
        if (well) begin
            it.meas_a = $signed(it.meas_a) >>> $urandom_range(12);
            it.meas_b = $signed(it.meas_b) >>> $urandom_range(12);
            it.want_d = $signed(it.want_d) >>> $urandom_range(12);
            it.want_q = $signed(it.want_q) >>> $urandom_range(12);
        end
        it.phase = 16'($urandom);
        it.freq = well ? 14'($urandom_range(10000)) : 14'($urandom);
        return it;
    endfunction

    typedef struct {
        t_item       it;
        bit          has_exp;
        logic [31:0] va, vb;
    } t_row;

    t_row rows[$];

    initial begin
        t_item it;
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        n_err = 0; n_sent = 0; quiet = 0;
        idle_pct = 0; stall_pct = 0; hold_out = 0;
        kp = prgcc_pkg::PROP_GAIN_RST; ki = prgcc_pkg::INTEG_GAIN_RST;
        dt = prgcc_pkg::SUBSTEP_TIME_RST;
        nsub = prgcc_pkg::OVERSAMPLE_RST; rlim = prgcc_pkg::RATE_LIMIT_RST;
        clear_ctrl();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero item after reset gives zero; extremes; frequency beyond range
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, 32'd0, 32'd0});
        rows.push_back('{'{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                           16'hFFFF, 14'h3FFF}, 0, 0, 0});
        rows.push_back('{'{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                           16'h4000, 14'd10000}, 0, 0, 0});
        rows.push_back('{'{24'sh001000, -24'sh001000, 24'sh004000, 24'sh0, 16'h8000,
                           14'd5000}, 0, 0, 0});
        rows.push_back('{'{0, 0, 0, 0, 16'hC000, 14'd0}, 0, 0, 0});
        rows.push_back('{'{24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 16'h2000, 14'd6000}, 0, 0, 0});
        foreach (rows[i]) send_item(rows[i].it, rows[i].has_exp, rows[i].va, rows[i].vb);
        drain();

        // gain extremes; all-zero item after a gain write must give zero
        write_reg(prgcc_pkg::REG_PROP_GAIN, 40'hFFFFFF);
        write_reg(prgcc_pkg::REG_INTEG_GAIN, 40'hFFFFFFF);
        write_reg(prgcc_pkg::REG_SUBSTEP_TIME, 40'hFF_FFFF_FFFF);
        write_reg(prgcc_pkg::REG_OVERSAMPLE, 5'd31);
        write_reg(prgcc_pkg::REG_RATE_LIMIT, 40'h7FFFFF);
        send_item('{0, 0, 0, 0, 0, 0}, 1, 32'd0, 32'd0);
        for (int i = 0; i < 6; i++) send_item(rand_item(i[0]), 0, 0, 0);
        drain();
        write_reg(prgcc_pkg::REG_PROP_GAIN, 0);
        write_reg(prgcc_pkg::REG_INTEG_GAIN, 0);
        write_reg(prgcc_pkg::REG_SUBSTEP_TIME, 0);
        write_reg(prgcc_pkg::REG_OVERSAMPLE, 0);
        write_reg(prgcc_pkg::REG_RATE_LIMIT, 0);
        write_reg(prgcc_pkg::t_reg_idx'(3'd7), 40'h12345);
        for (int i = 0; i < 4; i++) send_item(rand_item(1), 0, 0, 0);
        drain();

        // random phases with varied settings, input idling and output stalls
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(prgcc_pkg::REG_PROP_GAIN,
                      ph == 0 ? prgcc_pkg::PROP_GAIN_RST : $urandom_range(60000));
            write_reg(prgcc_pkg::REG_INTEG_GAIN,
                      ph == 0 ? prgcc_pkg::INTEG_GAIN_RST : $urandom_range(4000000));
            write_reg(prgcc_pkg::REG_SUBSTEP_TIME, ph == 0 ? prgcc_pkg::SUBSTEP_TIME_RST :
                      40'($urandom_range(200000000)) + 1);
            write_reg(prgcc_pkg::REG_OVERSAMPLE,
                      ph == 4 ? $urandom_range(31) : $urandom_range(3) + 1);
            write_reg(prgcc_pkg::REG_RATE_LIMIT, $urandom_range(ph == 3 ? 8388607 : 20000));
            case (ph)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 53; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 53; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            if (ph == 2) begin
                fork
                    begin
                        hold_out = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_out = 0;
                    end
                join_none
            end
            for (int i = 0; i < 345; i++) send_item(rand_item($urandom_range(9) != 0), 0, 0, 0);
            drain();
        end

        if (n_err == 0 && volt_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
